// ----- hdl/pvmt_pkg.sv -----
package pvmt_pkg;

  localparam int MAX_DIM   = 4;
  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;

  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + $clog2(LANES);
  localparam int DIM_W  = 3;
  localparam int MD_W   = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [DIM_W-1:0]         dim_t;

  localparam word_t COEF_ONE = WORD_W'(64'd1 << FRAC_BITS);
  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    logic prod_en;
    logic on;
  } lane_ctl_t;

  typedef struct packed {
    logic en;
    logic vld;
    dim_t dim;
  } merge_ctl_t;

endpackage

// ----- hdl/pvmt_lane.sv -----
module pvmt_lane (
  input  logic                  clk,
  input  pvmt_pkg::lane_ctl_t   ctl,
  input  pvmt_pkg::word_t       x_i [pvmt_pkg::LANES],
  input  pvmt_pkg::word_t       c_i [pvmt_pkg::LANES],
  output pvmt_pkg::word_t       y_o,
  output logic                  sat_o
);
  import pvmt_pkg::*;

  prod_t prod_r [LANES];
  logic  on_r;
  sum_t  sum;
  logic signed [SUM_W-FRAC_BITS-1:0] sh;

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      for (int j = 0; j < LANES; j++) begin
        prod_r[j] <= PROD_W'(x_i[j] * c_i[j]);
      end
      on_r <= ctl.on;
    end
  end

  // exact sum, then floor shift (arithmetic) and clip to one word
  always_comb begin
    sum = '0;
    for (int j = 0; j < LANES; j++) begin
      sum = sum + SUM_W'(prod_r[j]);
    end
    sh = (SUM_W-FRAC_BITS)'(sum >>> FRAC_BITS);
    y_o   = '0;
    sat_o = 1'b0;
    if (on_r) begin
      if (sh > (SUM_W-FRAC_BITS)'(WORD_MAX)) begin
        y_o   = WORD_MAX;
        sat_o = 1'b1;
      end else if (sh < (SUM_W-FRAC_BITS)'(WORD_MIN)) begin
        y_o   = WORD_MIN;
        sat_o = 1'b1;
      end else begin
        y_o = WORD_W'(sh);
      end
    end
  end

endmodule

// ----- hdl/pvmt_merge.sv -----
module pvmt_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pvmt_pkg::merge_ctl_t   ctl,
  input  pvmt_pkg::word_t        y_i [pvmt_pkg::LANES],
  input  logic [pvmt_pkg::LANES-1:0] sat_i,
  output logic                   valid_o,
  output pvmt_pkg::word_t        y_o [pvmt_pkg::LANES],
  output pvmt_pkg::dim_t         dim_o,
  output logic                   sat_o
);
  import pvmt_pkg::*;

  logic  valid_r, valid_nxt;
  word_t y_r [LANES];
  dim_t  dim_r;
  logic  sat_r;

  assign valid_nxt = ctl.en ? ctl.vld : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      y_r   <= y_i;
      dim_r <= ctl.dim;
      sat_r <= |sat_i;
    end
  end

  assign valid_o = valid_r;
  assign y_o     = y_r;
  assign dim_o   = dim_r;
  assign sat_o   = sat_r;

endmodule

// ----- hdl/padded_vector_matrix_transform_top.sv -----
// Transform items pass the capture, multiply and sum/clip registers before out_valid.
// Throughput: one item per cycle unless stalled; four lanes of four multipliers each.
// Load items give no result and apply to the next transform item.
// Backpressure fills pipeline bubbles before in_stall rises.
// Reset (rst_n low, synchronous): matrix store to identity, matrix_dim to 4, pipeline empty.
module padded_vector_matrix_transform_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [1:0]               in_row,
  input  logic [1:0]               in_col,
  input  pvmt_pkg::word_t          in_coeff,
  input  pvmt_pkg::dim_t           in_vec_dim,
  input  pvmt_pkg::word_t          in_x0,
  input  pvmt_pkg::word_t          in_x1,
  input  pvmt_pkg::word_t          in_x2,
  input  pvmt_pkg::word_t          in_x3,
  output logic                     out_valid,
  input  logic                     out_stall,
  output pvmt_pkg::word_t          out_y0,
  output pvmt_pkg::word_t          out_y1,
  output pvmt_pkg::word_t          out_y2,
  output pvmt_pkg::word_t          out_y3,
  output pvmt_pkg::dim_t           out_out_dim,
  output logic                     out_saturated
);
  import pvmt_pkg::*;

  logic [2:0] matrix_dim_r;
  word_t      store_r [MAX_DIM][MAX_DIM];

  logic       accept, is_load, is_xform;
  logic       en1, en2, en_out;
  logic       v1_r, v2_r;
  dim_t       od1_r, od2_r;
  logic [LANES-1:0] on1_r;

  logic [MD_W-1:0] md, odw;
  dim_t       vd, od;
  word_t      x_in  [LANES];
  word_t      x_m   [LANES];
  word_t      coef  [LANES][LANES];
  word_t      x1_r  [LANES];
  word_t      coef1_r [LANES][LANES];

  word_t      lane_y [LANES];
  logic [LANES-1:0] lane_sat;
  word_t      y_out [LANES];
  merge_ctl_t mctl;

  assign accept   = in_valid && !in_stall;
  assign is_load  = accept && (op_t'(in_op) == OP_LOAD);
  assign is_xform = accept && (op_t'(in_op) == OP_XFORM);

  // stall chain: each stage moves when its successor has room
  assign en_out   = !out_valid || !out_stall;
  assign en2      = !v2_r || en_out;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_dim_r <= 3'd4;
    end else if (cfg_we) begin
      matrix_dim_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        if (!rst_n) begin
          store_r[r][c] <= (r == c) ? COEF_ONE : '0;
        end else if (is_load && MD_W'(in_row) == MD_W'(r) && MD_W'(in_col) == MD_W'(c)) begin
          store_r[r][c] <= in_coeff;
        end
      end
    end
  end

  assign x_in[0] = in_x0;
  assign x_in[1] = in_x1;
  assign x_in[2] = in_x2;
  assign x_in[3] = in_x3;

  always_comb begin
    md = ({1'b0, matrix_dim_r} > MD_W'(MAX_DIM)) ? MD_W'(MAX_DIM) : {1'b0, matrix_dim_r};
    vd = (in_vec_dim > DIM_W'(LANES)) ? DIM_W'(LANES) : in_vec_dim;
    odw = (md > {1'b0, vd}) ? md : {1'b0, vd};
    if (odw > MD_W'(LANES)) begin
      odw = MD_W'(LANES);
    end
    if (odw == '0) begin
      odw = MD_W'(1);
    end
    od = DIM_W'(odw);
    for (int j = 0; j < LANES; j++) begin
      x_m[j] = (DIM_W'(j) < vd) ? x_in[j] : '0;
    end
  end

  // identity padding outside the configured dimension
  for (genvar j = 0; j < LANES; j++) begin : g_row
    for (genvar i = 0; i < LANES; i++) begin : g_col
      if (j < MAX_DIM && i < MAX_DIM) begin : g_st
        assign coef[j][i] = (MD_W'(j) < md && MD_W'(i) < md) ? store_r[j][i] :
                            ((j == i) ? COEF_ONE : '0);
      end else begin : g_id
        assign coef[j][i] = (j == i) ? COEF_ONE : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= is_xform;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r    <= x_m;
      coef1_r <= coef;
      od1_r   <= od;
      for (int i = 0; i < LANES; i++) begin
        on1_r[i] <= (DIM_W'(i) < od);
      end
    end
    if (en2) begin
      od2_r <= od1_r;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    word_t     col [LANES];
    lane_ctl_t lctl;

    for (genvar j = 0; j < LANES; j++) begin : g_c
      assign col[j] = coef1_r[j][i];
    end

    assign lctl.prod_en = en2;
    assign lctl.on      = on1_r[i];

    pvmt_lane u_lane (
      .clk   (clk),
      .ctl   (lctl),
      .x_i   (x1_r),
      .c_i   (col),
      .y_o   (lane_y[i]),
      .sat_o (lane_sat[i])
    );
  end

  assign mctl.en  = en_out;
  assign mctl.vld = v2_r;
  assign mctl.dim = od2_r;

  pvmt_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .y_i     (lane_y),
    .sat_i   (lane_sat),
    .valid_o (out_valid),
    .y_o     (y_out),
    .dim_o   (out_out_dim),
    .sat_o   (out_saturated)
  );

  assign out_y0 = y_out[0];
  assign out_y1 = y_out[1];
  assign out_y2 = y_out[2];
  assign out_y3 = y_out[3];

endmodule

// ----- hdl/pvmt_checker.sv -----
module pvmt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input pvmt_pkg::word_t     out_y0,
  input pvmt_pkg::word_t     out_y1,
  input pvmt_pkg::word_t     out_y2,
  input pvmt_pkg::word_t     out_y3,
  input pvmt_pkg::dim_t      out_out_dim,
  input logic                out_saturated
);
  import pvmt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_out_dim != 3'd0) && (out_out_dim <= 3'(LANES)))
    else $error("out_dim out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_out_dim < 3'd4) |-> (out_y3 == '0))
    else $error("unused lane not zero");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_y0 == WORD_MAX) || (out_y0 == WORD_MIN) ||
      (out_y1 == WORD_MAX) || (out_y1 == WORD_MIN) ||
      (out_y2 == WORD_MAX) || (out_y2 == WORD_MIN) ||
      (out_y3 == WORD_MAX) || (out_y3 == WORD_MIN))
    else $error("saturated flag without clipped element");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item after reset");

endmodule

bind padded_vector_matrix_transform_top pvmt_checker u_pvmt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_y0        (out_y0),
  .out_y1        (out_y1),
  .out_y2        (out_y2),
  .out_y3        (out_y3),
  .out_out_dim   (out_out_dim),
  .out_saturated (out_saturated)
);

// ----- tb/padded_vector_matrix_transform_top_tb.sv -----
module padded_vector_matrix_transform_top_tb;
  import pvmt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam int N_PHASES     = 8;
  localparam logic [2:0] PHASE_MDIM [N_PHASES] =
    '{3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6};

  typedef struct packed {
    op_t         op;
    logic [1:0]  row;
    logic [1:0]  col;
    word_t       coeff;
    dim_t        vec_dim;
    word_t [3:0] x;
  } xfer_item_t;

  typedef struct packed {
    word_t [3:0] y;
    dim_t        out_dim;
    logic        saturated;
  } xform_res_t;

  typedef struct packed {
    logic [2:0] mdim;
    xfer_item_t item;
    logic       fixed_res;
    xform_res_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_op = 1'b0;
  logic [1:0] in_row = '0;
  logic [1:0] in_col = '0;
  word_t      in_coeff = '0;
  dim_t       in_vec_dim = '0;
  word_t      in_x0 = '0;
  word_t      in_x1 = '0;
  word_t      in_x2 = '0;
  word_t      in_x3 = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  word_t      out_y0;
  word_t      out_y1;
  word_t      out_y2;
  word_t      out_y3;
  dim_t       out_out_dim;
  logic       out_saturated;

  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  // predictor state
  word_t      coef_mem [MAX_DIM][MAX_DIM];
  logic [2:0] mdim_cur;
  xform_res_t xform_expect_q [$];

  padded_vector_matrix_transform_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_coeff     (in_coeff),
    .in_vec_dim   (in_vec_dim),
    .in_x0        (in_x0),
    .in_x1        (in_x1),
    .in_x2        (in_x2),
    .in_x3        (in_x3),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_y0       (out_y0),
    .out_y1       (out_y1),
    .out_y2       (out_y2),
    .out_y3       (out_y3),
    .out_out_dim  (out_out_dim),
    .out_saturated(out_saturated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic xfer_item_t mk_load(logic [1:0] r, logic [1:0] c, word_t k);
    xfer_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.row = r;
    it.col = c;
    it.coeff = k;
    return it;
  endfunction

  function automatic xfer_item_t mk_xform(dim_t vd, word_t a, word_t b, word_t c, word_t d);
    xfer_item_t it;
    it = '0;
    it.op = OP_XFORM;
    it.vec_dim = vd;
    it.x = {d, c, b, a};
    return it;
  endfunction

  function automatic xform_res_t mk_res(word_t a, word_t b, word_t c, word_t d,
                                        dim_t dm, logic s);
    xform_res_t r;
    r.y = {d, c, b, a};
    r.out_dim = dm;
    r.saturated = s;
    return r;
  endfunction

  // coefficient with identity padding outside the active dimension
  function automatic word_t coef_seen(int r, int c, int md);
    if (r < md && c < md) return coef_mem[r][c];
    return (r == c) ? COEF_ONE : '0;
  endfunction

  function automatic xform_res_t predict_xform(xfer_item_t it);
    int md, vd, od, i, j;
    sum_t acc, xv, cv, q, hi_lim, lo_lim;
    xform_res_t r;
    md = (mdim_cur > MAX_DIM) ? MAX_DIM : int'(mdim_cur);
    vd = (it.vec_dim > LANES) ? LANES : int'(it.vec_dim);
    od = (vd > md) ? vd : md;
    if (od > LANES) od = LANES;
    if (od < 1) od = 1;
    r = '0;
    r.out_dim = dim_t'(od);
    hi_lim = WORD_MAX;
    lo_lim = WORD_MIN;
    for (i = 0; i < LANES; i++) begin
      if (i < od) begin
        acc = '0;
        for (j = 0; j < vd; j++) begin
          xv = $signed(it.x[j]);
          cv = coef_seen(j, i, md);
          acc = acc + xv * cv;
        end
        q = acc >>> FRAC_BITS;  // floor
        if (q > hi_lim) begin
          r.y[i] = WORD_MAX;
          r.saturated = 1'b1;
        end else if (q < lo_lim) begin
          r.y[i] = WORD_MIN;
          r.saturated = 1'b1;
        end else begin
          r.y[i] = word_t'(q);
        end
      end
    end
    return r;
  endfunction

  // half small values so sums stay in range, the rest extremes and full-range words
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3, 4: return word_t'($urandom);
      default: return word_t'(int'($urandom_range(0, 524287)) - 262144);
    endcase
  endfunction

  function automatic xfer_item_t rand_item();
    xfer_item_t it;
    int j;
    it.op = ($urandom_range(0, 99) < 30) ? OP_LOAD : OP_XFORM;
    it.row = 2'($urandom);
    it.col = 2'($urandom);
    it.coeff = rand_word();
    if ($urandom_range(0, 7) == 0) it.vec_dim = dim_t'($urandom_range(0, 7));
    else it.vec_dim = dim_t'($urandom_range(1, 4));
    for (j = 0; j < LANES; j++) it.x[j] = rand_word();
    return it;
  endfunction

  task automatic send_item(xfer_item_t it, logic use_fixed, xform_res_t fixed);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_op      <= it.op;
    in_row     <= it.row;
    in_col     <= it.col;
    in_coeff   <= it.coeff;
    in_vec_dim <= it.vec_dim;
    in_x0      <= it.x[0];
    in_x1      <= it.x[1];
    in_x2      <= it.x[2];
    in_x3      <= it.x[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_LOAD) coef_mem[it.row][it.col] = it.coeff;
    else xform_expect_q.push_back(use_fixed ? fixed : predict_xform(it));
  endtask

  // drain first so the new dimension only hits items sent after it
  task automatic set_matrix_dim(logic [2:0] v);
    in_valid <= 1'b0;
    while (xform_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdim_cur = v;
  endtask

  always @(posedge clk) begin
    xform_res_t got, want;
    int i;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.y = {out_y3, out_y2, out_y1, out_y0};
        got.out_dim = out_out_dim;
        got.saturated = out_saturated;
        if (xform_expect_q.size() == 0) begin
          $error("unexpected result item: y0 %h y1 %h y2 %h y3 %h", out_y0, out_y1,
                 out_y2, out_y3);
          err_cnt++;
        end else begin
          want = xform_expect_q.pop_front();
          for (i = 0; i < LANES; i++) begin
            if (got.y[i] !== want.y[i]) begin
              $error("y%0d: expected %h, got %h", i, want.y[i], got.y[i]);
              err_cnt++;
            end
          end
          if (got.out_dim !== want.out_dim) begin
            $error("out_dim: expected %0d, got %0d", want.out_dim, got.out_dim);
            err_cnt++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            err_cnt++;
          end
        end
      end
      out_stall <= (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    int r, c, ph;
    for (r = 0; r < MAX_DIM; r++)
      for (c = 0; c < MAX_DIM; c++)
        coef_mem[r][c] = (r == c) ? COEF_ONE : '0;
    mdim_cur = 3'd4;

    // identity matrix after reset passes the vector through
    dir_tab.push_back('{3'd4, mk_xform(3'd4, WORD_MAX, WORD_MIN, COEF_ONE, 32'hFFFF_0000),
      1'b1, mk_res(WORD_MAX, WORD_MIN, COEF_ONE, 32'hFFFF_0000, 3'd4, 1'b0)});
    dir_tab.push_back('{3'd4, mk_xform(3'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX),
      1'b1, mk_res('0, '0, '0, '0, 3'd4, 1'b0)});
    dir_tab.push_back('{3'd4, mk_xform(3'd7, 32'h0003_8000, WORD_MIN, WORD_MAX, 32'h1),
      1'b1, mk_res(32'h0003_8000, WORD_MIN, WORD_MAX, 32'h1, 3'd4, 1'b0)});
    // short vector: missing elements are zero
    dir_tab.push_back('{3'd4, mk_xform(3'd2, COEF_ONE, 32'hFFFE_0000, WORD_MAX, WORD_MIN),
      1'b1, mk_res(COEF_ONE, 32'hFFFE_0000, '0, '0, 3'd4, 1'b0)});
    dir_tab.push_back('{3'd4, mk_load(2'd0, 2'd0, WORD_MAX), 1'b0, '0});
    dir_tab.push_back('{3'd4, mk_load(2'd3, 2'd3, WORD_MIN), 1'b0, '0});
    dir_tab.push_back('{3'd4, mk_load(2'd1, 2'd2, 32'h0002_0000), 1'b0, '0});
    dir_tab.push_back('{3'd4, mk_load(2'd2, 2'd1, 32'hFFFF_8000), 1'b0, '0});
    dir_tab.push_back('{3'd4, mk_load(2'd0, 2'd3, 32'h0000_0001), 1'b0, '0});
    dir_tab.push_back('{3'd4, mk_xform(3'd4, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX),
      1'b0, '0});
    dir_tab.push_back('{3'd4, mk_xform(3'd4, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN),
      1'b0, '0});
    dir_tab.push_back('{3'd4, mk_xform(3'd4, 32'hFFFF_FFFF, 32'h0001_8000, 32'hFFFD_0000,
      32'h0000_4000), 1'b0, '0});
    // coefficient outside the active dimension is stored but unused
    dir_tab.push_back('{3'd1, mk_load(2'd3, 2'd0, 32'h0005_0000), 1'b0, '0});
    dir_tab.push_back('{3'd1, mk_xform(3'd3, WORD_MAX, COEF_ONE, WORD_MIN, '0), 1'b0, '0});
    dir_tab.push_back('{3'd1, mk_xform(3'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX),
      1'b1, mk_res('0, '0, '0, '0, 3'd1, 1'b0)});
    // zero dimension: whole matrix acts as identity
    dir_tab.push_back('{3'd0, mk_xform(3'd0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN),
      1'b1, mk_res('0, '0, '0, '0, 3'd1, 1'b0)});
    dir_tab.push_back('{3'd0, mk_xform(3'd2, WORD_MIN, WORD_MAX, COEF_ONE, COEF_ONE),
      1'b1, mk_res(WORD_MIN, WORD_MAX, '0, '0, 3'd2, 1'b0)});
    dir_tab.push_back('{3'd0, mk_xform(3'd4, 32'h1234_5678, 32'h8765_4321, 32'h1, WORD_MIN),
      1'b1, mk_res(32'h1234_5678, 32'h8765_4321, 32'h1, WORD_MIN, 3'd4, 1'b0)});
    // dimension above the store size clamps
    dir_tab.push_back('{3'd7, mk_xform(3'd4, COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE),
      1'b0, '0});
    dir_tab.push_back('{3'd7, mk_xform(3'd1, 32'h0002_0000, WORD_MAX, WORD_MAX, WORD_MAX),
      1'b0, '0});
    dir_tab.push_back('{3'd4, mk_xform(3'd4, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
      32'h0003_0000), 1'b0, '0});
    dir_tab.push_back('{3'd4, mk_load(2'd1, 2'd1, '0), 1'b0, '0});
    dir_tab.push_back('{3'd4, mk_xform(3'd3, 32'hFFFF_FFFF, 32'h7FFF_0000, 32'h0001_0000,
      WORD_MAX), 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      if (k == 0 || dir_tab[k].mdim != mdim_cur) set_matrix_dim(dir_tab[k].mdim);
      send_item(dir_tab[k].item, dir_tab[k].fixed_res, dir_tab[k].res);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      set_matrix_dim(PHASE_MDIM[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (PHASE_ITEMS) send_item(rand_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (xform_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pvmt_pkg.sv
hdl/pvmt_lane.sv
hdl/pvmt_merge.sv
hdl/padded_vector_matrix_transform_top.sv
hdl/pvmt_checker.sv
tb/padded_vector_matrix_transform_top_tb.sv
